FILE: rtl/evr_pkg.sv
// Package for the Euler vector rotation block: widths, CORDIC constants and helpers.
package evr_pkg;

  localparam int unsigned COORD_WIDTH_DEF = 16;
  localparam int unsigned ANGLE_WIDTH_DEF = 16;
  localparam int unsigned TRIG_STAGES_DEF = 16;
  localparam int unsigned MAX_STAGES      = 24;

  // CORDIC datapath: 32-bit turn angle, Q30 magnitudes with headroom
  localparam int unsigned ZW = 32;
  localparam int unsigned CW = 34;
  localparam int unsigned TW = 19;
  localparam logic signed [CW-1:0] CORDIC_X0 = 34'sh026DD3B6A;

  function automatic logic [ZW-1:0] atan_turn(input int unsigned i);
    logic [ZW-1:0] t;
    case (i)
      0: t = 32'h20000000;  1: t = 32'h12E4051E;  2: t = 32'h09FB385B;
      3: t = 32'h051111D4;  4: t = 32'h028B0D43;  5: t = 32'h0145D7E1;
      6: t = 32'h00A2F61E;  7: t = 32'h00517C55;  8: t = 32'h0028BE53;
      9: t = 32'h00145F2F;  10: t = 32'h000A2F98; 11: t = 32'h000517CC;
      12: t = 32'h00028BE6; 13: t = 32'h000145F3; 14: t = 32'h0000A2FA;
      15: t = 32'h0000517D; 16: t = 32'h000028BE; 17: t = 32'h0000145F;
      18: t = 32'h00000A30; 19: t = 32'h00000518; 20: t = 32'h0000028C;
      21: t = 32'h00000146; 22: t = 32'h000000A3; 23: t = 32'h00000051;
      default: t = '0;
    endcase
    return t;
  endfunction

  // Q16 product rounded to Q16: floor((p*q + 2^15) / 2^16)
  function automatic logic signed [TW-1:0] mulq16(input logic signed [TW-1:0] p,
                                                  input logic signed [TW-1:0] q);
    logic signed [2*TW-1:0] m;
    m = (2*TW)'(p) * (2*TW)'(q) + (2*TW)'(32768);
    return TW'(m >>> 16);
  endfunction

endpackage

FILE: rtl/euler_vector_rotation.sv
// Top level: Z-Y-X Euler rotation of a 3-vector, fully pipelined.
// Throughput: one item per cycle; busy is held low, so start may be high every cycle.
// Angle prep, CORDIC, trig rounding, matrix stages and the output stages set the latency.
// Reset (rst_n low, synchronous) clears all valid bits; payload registers are not reset.
// The receiver cannot stall; each result is shown for exactly one cycle.
module euler_vector_rotation #(
  parameter int unsigned COORD_WIDTH = evr_pkg::COORD_WIDTH_DEF,
  parameter int unsigned ANGLE_WIDTH = evr_pkg::ANGLE_WIDTH_DEF,
  parameter int unsigned TRIG_STAGES = evr_pkg::TRIG_STAGES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [COORD_WIDTH-1:0] in_x,
  input  logic signed [COORD_WIDTH-1:0] in_y,
  input  logic signed [COORD_WIDTH-1:0] in_z,
  input  logic        [ANGLE_WIDTH-1:0] angle_a,
  input  logic        [ANGLE_WIDTH-1:0] angle_b,
  input  logic        [ANGLE_WIDTH-1:0] angle_c,
  output logic                          out_valid,
  output logic signed [COORD_WIDTH:0]   out_x,
  output logic signed [COORD_WIDTH:0]   out_y,
  output logic signed [COORD_WIDTH:0]   out_z
);
  import evr_pkg::*;

  localparam int unsigned NS = (TRIG_STAGES > MAX_STAGES) ? MAX_STAGES : TRIG_STAGES;
  localparam int unsigned OW = COORD_WIDTH + 1;
  localparam int unsigned PW = COORD_WIDTH + TW;
  localparam int unsigned SW = PW + 2;

  typedef logic signed [CW-1:0] cval_t;
  typedef logic signed [TW-1:0] trig_t;
  typedef logic signed [COORD_WIDTH-1:0] coord_t;

  assign busy = 1'b0;

  // angle prep stage
  logic [2:0]        flip_r [0:NS];
  logic [ZW-1:0]     z_r    [0:NS][3];
  cval_t             cx_r   [0:NS][3];
  cval_t             cy_r   [0:NS][3];
  coord_t            v_r    [0:NS][3];
  logic [NS:0]       vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r[0] <= 1'b0;
    else vld_r[0] <= start;
  end

  always_ff @(posedge clk) begin
    logic [ANGLE_WIDTH-1:0] ang [3];
    logic [ZW-1:0] t;
    ang[0] = angle_a; ang[1] = angle_b; ang[2] = angle_c;
    for (int k = 0; k < 3; k++) begin
      t = ZW'(ang[k]) << (ZW - ANGLE_WIDTH);
      flip_r[0][k] <= t[ZW-1] ^ t[ZW-2];
      z_r[0][k]    <= t + ((t[ZW-1] ^ t[ZW-2]) ? 32'h80000000 : 32'h0);
      cx_r[0][k]   <= CORDIC_X0;
      cy_r[0][k]   <= '0;
    end
    v_r[0][0] <= in_x; v_r[0][1] <= in_y; v_r[0][2] <= in_z;
  end

  for (genvar i = 0; i < NS; i++) begin : g_cordic
    always_ff @(posedge clk) begin
      if (!rst_n) vld_r[i+1] <= 1'b0;
      else vld_r[i+1] <= vld_r[i];
    end
    always_ff @(posedge clk) begin
      for (int k = 0; k < 3; k++) begin
        if (!z_r[i][k][ZW-1]) begin
          cx_r[i+1][k] <= cx_r[i][k] - (cy_r[i][k] >>> i);
          cy_r[i+1][k] <= cy_r[i][k] + (cx_r[i][k] >>> i);
          z_r[i+1][k]  <= z_r[i][k] - atan_turn(i);
        end else begin
          cx_r[i+1][k] <= cx_r[i][k] + (cy_r[i][k] >>> i);
          cy_r[i+1][k] <= cy_r[i][k] - (cx_r[i][k] >>> i);
          z_r[i+1][k]  <= z_r[i][k] + atan_turn(i);
        end
      end
      flip_r[i+1] <= flip_r[i];
      v_r[i+1]    <= v_r[i];
    end
  end

  // round to Q16 with fold-back negation
  trig_t  s_r [3], c_r [3];
  coord_t v1_r [3];
  logic   vld1_r;
  always_ff @(posedge clk) begin
    cval_t xs, ys;
    for (int k = 0; k < 3; k++) begin
      xs = flip_r[NS][k] ? -cx_r[NS][k] : cx_r[NS][k];
      ys = flip_r[NS][k] ? -cy_r[NS][k] : cy_r[NS][k];
      c_r[k] <= TW'((xs + CW'(8192)) >>> 14);
      s_r[k] <= TW'((ys + CW'(8192)) >>> 14);
    end
    v1_r <= v_r[NS];
  end

  // pairwise products
  trig_t sasb_r, casb_r, cbcc_r, casc_r, sasc_r, cbsc_r, cacc_r, sacc_r, sacb_r, cacb_r;
  trig_t sc2_r, cc2_r, sb2_r;
  coord_t v2_r [3];
  logic vld2_r;
  always_ff @(posedge clk) begin
    sasb_r <= mulq16(s_r[0], s_r[1]);
    casb_r <= mulq16(c_r[0], s_r[1]);
    cbcc_r <= mulq16(c_r[1], c_r[2]);
    casc_r <= mulq16(c_r[0], s_r[2]);
    sasc_r <= mulq16(s_r[0], s_r[2]);
    cbsc_r <= mulq16(c_r[1], s_r[2]);
    cacc_r <= mulq16(c_r[0], c_r[2]);
    sacc_r <= mulq16(s_r[0], c_r[2]);
    sacb_r <= mulq16(s_r[0], c_r[1]);
    cacb_r <= mulq16(c_r[0], c_r[1]);
    sc2_r <= s_r[2]; cc2_r <= c_r[2]; sb2_r <= s_r[1];
    v2_r <= v1_r;
  end

  // matrix entries
  trig_t m_r [3][3];
  coord_t v3_r [3];
  logic vld3_r;
  always_ff @(posedge clk) begin
    m_r[0][0] <= cbcc_r;
    m_r[0][1] <= mulq16(sasb_r, cc2_r) - casc_r;
    m_r[0][2] <= mulq16(casb_r, cc2_r) + sasc_r;
    m_r[1][0] <= cbsc_r;
    m_r[1][1] <= mulq16(sasb_r, sc2_r) + cacc_r;
    m_r[1][2] <= mulq16(casb_r, sc2_r) - sacc_r;
    m_r[2][0] <= -sb2_r;
    m_r[2][1] <= sacb_r;
    m_r[2][2] <= cacb_r;
    v3_r <= v2_r;
  end

  // vector products
  logic signed [PW-1:0] p_r [3][3];
  logic vld4_r;
  always_ff @(posedge clk) begin
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 3; c++)
        p_r[r][c] <= PW'(v3_r[c]) * PW'(m_r[r][c]);
  end

  // sums
  logic signed [SW-1:0] acc_r [3];
  logic vld5_r;
  always_ff @(posedge clk) begin
    for (int r = 0; r < 3; r++)
      acc_r[r] <= SW'(p_r[r][0]) + SW'(p_r[r][1]) + SW'(p_r[r][2]);
  end

  // round and saturate
  logic signed [OW-1:0] o_r [3];
  logic vld6_r;
  always_ff @(posedge clk) begin
    logic signed [SW-1:0] q;
    for (int r = 0; r < 3; r++) begin
      q = (acc_r[r] + SW'(32768)) >>> 16;
      if (q > SW'((65'sd1 <<< COORD_WIDTH) - 1))       o_r[r] <= {1'b0, {COORD_WIDTH{1'b1}}};
      else if (q < -SW'(65'sd1 <<< COORD_WIDTH))      o_r[r] <= {1'b1, {COORD_WIDTH{1'b0}}};
      else                                           o_r[r] <= OW'(q);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0; vld2_r <= 1'b0; vld3_r <= 1'b0;
      vld4_r <= 1'b0; vld5_r <= 1'b0; vld6_r <= 1'b0;
    end else begin
      vld1_r <= vld_r[NS]; vld2_r <= vld1_r; vld3_r <= vld2_r;
      vld4_r <= vld3_r; vld5_r <= vld4_r; vld6_r <= vld5_r;
    end
  end

  assign out_valid = vld6_r;
  assign out_x = o_r[0];
  assign out_y = o_r[1];
  assign out_z = o_r[2];

endmodule

FILE: rtl/evr_checker.sv
// Port-level checker for the Euler vector rotation block, bound to the top level.
module evr_checker #(
  parameter int unsigned LAT = evr_pkg::TRIG_STAGES_DEF + 7
) (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_valid
);
  import evr_pkg::*;

  logic [LAT-1:0] sh_r;
  always_ff @(posedge clk) begin
    if (!rst_n) sh_r <= '0;
    else sh_r <= {sh_r[LAT-2:0], start && !busy};
  end

  a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
    else $error("busy raised");
  a_valid_tracks: assert property (@(posedge clk) disable iff (!rst_n) out_valid == sh_r[LAT-1])
    else $error("result strobe does not match transfer latency");
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    (sh_r == '0) |-> !out_valid)
    else $error("result without transfer");
endmodule

bind euler_vector_rotation evr_checker #(
  .LAT((TRIG_STAGES > evr_pkg::MAX_STAGES ? evr_pkg::MAX_STAGES : TRIG_STAGES) + 7)
) u_evr_checker (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .out_valid(out_valid)
);

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps
// Testbench for euler_vector_rotation: random and directed vectors checked against a CORDIC model.
module testbench;
  import evr_pkg::*;

  localparam int unsigned CWID = 16;
  localparam int unsigned AWID = 16;
  localparam int unsigned NSTG = 16;
  localparam int unsigned LAT  = NSTG + 7;
  localparam int WD_LIMIT      = 2000;

  typedef struct packed {
    logic signed [CWID-1:0] x, y, z;
    logic [AWID-1:0] a, b, c;
  } vec_item_t;

  typedef struct packed {
    logic signed [CWID:0] x, y, z;
  } rot_vec_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic signed [CWID-1:0] in_x = '0, in_y = '0, in_z = '0;
  logic [AWID-1:0] angle_a = '0, angle_b = '0, angle_c = '0;
  logic out_valid;
  logic signed [CWID:0] out_x, out_y, out_z;

  euler_vector_rotation dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_x(in_x), .in_y(in_y), .in_z(in_z),
    .angle_a(angle_a), .angle_b(angle_b), .angle_c(angle_c),
    .out_valid(out_valid), .out_x(out_x), .out_y(out_y), .out_z(out_z)
  );

  vec_item_t pending_q[$];
  rot_vec_t  rotated_q[$];
  int errors = 0;
  int idle_cnt = 0;
  int watchdog = 0;
  bit calm = 1'b0;
  bit drain_req = 1'b0;
  bit stim_done = 1'b0;

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic longint fshift(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint qmul(longint p, longint q);
    return fshift(p * q + 32768, 16);
  endfunction

  function automatic void trig_q16(logic [AWID-1:0] ang, output longint s, output longint c);
    logic [31:0] t;
    longint x, y, z, xs, ys;
    bit flip;
    t = {ang, {(32-AWID){1'b0}}};
    flip = (t[31:30] == 2'b01) || (t[31:30] == 2'b10);
    if (flip) t = t + 32'h8000_0000;
    z = longint'($signed(t));
    x = 64'h26DD3B6A;
    y = 0;
    for (int i = 0; i < NSTG; i++) begin
      xs = fshift(x, i);
      ys = fshift(y, i);
      if (z >= 0) begin
        x = x - ys; y = y + xs; z = z - longint'(atan_turn(i));
      end else begin
        x = x + ys; y = y - xs; z = z + longint'(atan_turn(i));
      end
    end
    if (flip) begin
      x = -x; y = -y;
    end
    c = fshift(x + 8192, 14);
    s = fshift(y + 8192, 14);
  endfunction

  function automatic logic signed [CWID:0] round_sat(longint acc);
    longint r;
    r = fshift(acc + 32768, 16);
    if (r > (longint'(1) <<< CWID) - 1) r = (longint'(1) <<< CWID) - 1;
    if (r < -(longint'(1) <<< CWID)) r = -(longint'(1) <<< CWID);
    return r[CWID:0];
  endfunction

  function automatic rot_vec_t rotate_zyx(vec_item_t v);
    longint sa, ca, sb, cb, sc, cc, sasb, casb, vx, vy, vz;
    longint m00, m01, m02, m10, m11, m12, m20, m21, m22;
    rot_vec_t r;
    trig_q16(v.a, sa, ca);
    trig_q16(v.b, sb, cb);
    trig_q16(v.c, sc, cc);
    vx = v.x; vy = v.y; vz = v.z;
    sasb = qmul(sa, sb);
    casb = qmul(ca, sb);
    m00 = qmul(cb, cc);
    m01 = qmul(sasb, cc) - qmul(ca, sc);
    m02 = qmul(casb, cc) + qmul(sa, sc);
    m10 = qmul(cb, sc);
    m11 = qmul(sasb, sc) + qmul(ca, cc);
    m12 = qmul(casb, sc) - qmul(sa, cc);
    m20 = -sb;
    m21 = qmul(sa, cb);
    m22 = qmul(ca, cb);
    r.x = round_sat(vx * m00 + vy * m01 + vz * m02);
    r.y = round_sat(vx * m10 + vy * m11 + vz * m12);
    r.z = round_sat(vx * m20 + vy * m21 + vz * m22);
    return r;
  endfunction

  task automatic report_mismatch(string what, logic signed [CWID:0] got,
                                 logic signed [CWID:0] want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
    errors++;
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        rotated_q.insert(rotated_q.size(),
                         rotate_zyx({in_x, in_y, in_z, angle_a, angle_b, angle_c}));
      end
      if (start && busy) begin
        // hold current item
      end else if (idle_cnt > 0) begin
        idle_cnt <= idle_cnt - 1;
        start <= 1'b0;
      end else if (drain_req && (rotated_q.size() != 0 || (start && !busy))) begin
        start <= 1'b0;
      end else if (pending_q.size() != 0 && !calm && $urandom_range(0, 9) == 0) begin
        idle_cnt <= $urandom_range(0, 7);
        start <= 1'b0;
      end else if (pending_q.size() != 0) begin
        vec_item_t v;
        v = pending_q.pop_front();
        in_x <= v.x; in_y <= v.y; in_z <= v.z;
        angle_a <= v.a; angle_b <= v.b; angle_c <= v.c;
        start <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (rotated_q.size() == 0) begin
        $display("unexpected result transfer at %0t", $time);
        errors++;
      end else begin
        rot_vec_t w;
        w = rotated_q.pop_front();
        if (out_x !== w.x) report_mismatch("out_x", out_x, w.x);
        if (out_y !== w.y) report_mismatch("out_y", out_y, w.y);
        if (out_z !== w.z) report_mismatch("out_z", out_z, w.z);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((start && !busy) || out_valid || !rst_n) watchdog <= 0;
    else watchdog <= watchdog + 1;
    if (watchdog >= WD_LIMIT) begin
      $display("FAIL euler_vector_rotation");
      $finish;
    end
  end

  function automatic vec_item_t rand_item();
    vec_item_t v;
    v.x = CWID'($urandom); v.y = CWID'($urandom); v.z = CWID'($urandom);
    v.a = AWID'($urandom); v.b = AWID'($urandom); v.c = AWID'($urandom);
    if ($urandom_range(0, 5) == 0) v.a = {3'($urandom_range(0, 7)), {(AWID-3){1'b0}}};
    if ($urandom_range(0, 5) == 0) v.b = {3'($urandom_range(0, 7)), {(AWID-3){1'b0}}};
    if ($urandom_range(0, 5) == 0) v.c = {3'($urandom_range(0, 7)), {(AWID-3){1'b0}}};
    if ($urandom_range(0, 7) == 0) v.x = $urandom_range(0, 1) ? 16'sh7FFF : -16'sh8000;
    return v;
  endfunction

  initial begin
    logic [AWID-1:0] angs[6];
    angs = '{16'h0000, 16'h4000, 16'h8000, 16'hC000, 16'hFFFF, 16'h3FFF};
    for (int i = 0; i < 6; i++)
      pending_q.insert(pending_q.size(), {16'sh7FFF, -16'sh8000, 16'sh7FFF,
                                          angs[i], angs[(i+1)%6], angs[(i+2)%6]});
    pending_q.insert(pending_q.size(),
                     {-16'sh8000, -16'sh8000, -16'sh8000, 16'h2000, 16'h6000, 16'hA000});
    pending_q.insert(pending_q.size(),
                     {16'sh0000, 16'sh0000, 16'sh0000, 16'hFFFF, 16'hFFFF, 16'hFFFF});
    pending_q.insert(pending_q.size(),
                     {16'sh0100, 16'sh0000, 16'sh0000, 16'h4000, 16'h4000, 16'h4000});
    pending_q.insert(pending_q.size(),
                     {16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'hE000, 16'h2000, 16'h6000});
    pending_q.insert(pending_q.size(),
                     {-16'sh0001, 16'sh0001, 16'sh5555, 16'h8001, 16'h7FFF, 16'h0001});
    pending_q.insert(pending_q.size(),
                     {16'shAAAA, 16'sh5555, 16'shAAAA, 16'h5555, 16'hAAAA, 16'hC001});
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    for (int i = 0; i < 550; i++) pending_q.insert(pending_q.size(), rand_item());
    wait (pending_q.size() == 0);
    drain_req = 1'b1;
    @(posedge clk);
    wait (rotated_q.size() == 0 && !start);
    @(posedge clk);
    drain_req = 1'b0;
    for (int i = 0; i < 400; i++) pending_q.insert(pending_q.size(), rand_item());
    wait (pending_q.size() == 0);
    calm = 1'b1;
    for (int i = 0; i < 200; i++) pending_q.insert(pending_q.size(), rand_item());
    wait (pending_q.size() == 0);
    @(posedge clk);
    wait (rotated_q.size() == 0 && !start);
    repeat (LAT + 5) @(posedge clk);
    if (errors == 0) $display("PASS euler_vector_rotation");
    else $display("FAIL euler_vector_rotation");
    $finish;
  end

endmodule
